// ===== hw/rtl/lcdpal_pkg.sv =====
// lcdpal_pkg: shared constants, types and request codes for the LCD palette
// register block. Used by lcdpal_cram and lcd_palette_register_block.
// No dependencies.
`default_nettype none

package lcdpal_pkg;

  localparam int unsigned SCREEN_WIDTH    = 160;
  localparam int unsigned COLOR_RAM_WORDS = 32;
  localparam int unsigned CRAM_AW         = $clog2(COLOR_RAM_WORDS);

  // request kinds carried in s_axis_tuser
  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_RENDER = 2'd2,
    MODE_STATUS = 2'd3
  } mode_e;

  // register map
  localparam logic [15:0] ADDR_CONTROL = 16'hFF40;
  localparam logic [15:0] ADDR_STATUS  = 16'hFF41;
  localparam logic [15:0] ADDR_SCY     = 16'hFF42;
  localparam logic [15:0] ADDR_SCX     = 16'hFF43;
  localparam logic [15:0] ADDR_LINE    = 16'hFF44;
  localparam logic [15:0] ADDR_LCMP    = 16'hFF45;
  localparam logic [15:0] ADDR_BGPAL   = 16'hFF47;
  localparam logic [15:0] ADDR_OBPAL0  = 16'hFF48;
  localparam logic [15:0] ADDR_OBPAL1  = 16'hFF49;
  localparam logic [15:0] ADDR_WY      = 16'hFF4A;
  localparam logic [15:0] ADDR_WX      = 16'hFF4B;
  localparam logic [15:0] ADDR_BGPTR   = 16'hFF68;
  localparam logic [15:0] ADDR_BGDATA  = 16'hFF69;
  localparam logic [15:0] ADDR_OBPTR   = 16'hFF6A;
  localparam logic [15:0] ADDR_OBDATA  = 16'hFF6B;

  localparam logic [7:0]  BYTE_ALL_ONES   = 8'hFF;
  localparam logic [7:0]  STATUS_WR_MASK  = 8'hFC;
  localparam logic [7:0]  PTR_AUTO_INC    = 8'h80;
  localparam logic [15:0] COLOR_WRITTEN   = 16'h8000;

  typedef logic [15:0] shade_tbl_t [4];
  localparam shade_tbl_t SHADES = '{16'hEBFC, 16'hBB11, 16'hA9A6, 16'h9061};

  typedef struct packed {
    logic               en;
    logic [CRAM_AW-1:0] addr;
  } cram_rd_t;

  typedef struct packed {
    logic               en;
    logic [CRAM_AW-1:0] addr;
    logic [15:0]        data;
  } cram_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lcdpal_cram.sv =====
// lcdpal_cram: one 32 x 16 color palette RAM, registered read, one write port.
// Per-entry valid bits make the whole RAM read as zero after reset.
// Depends on lcdpal_pkg.
`default_nettype none

module lcdpal_cram (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lcdpal_pkg::cram_rd_t rd_i,
  input  wire lcdpal_pkg::cram_wr_t wr_i,
  output logic [15:0]               rdata_o
);

  logic [15:0] mem_q [lcdpal_pkg::COLOR_RAM_WORDS];
  logic [lcdpal_pkg::COLOR_RAM_WORDS-1:0] vld_q;
  logic [15:0] rdata_q;
  logic        rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rvld_q <= vld_q[rd_i.addr];
      end
    end
  end

  // never-written entries read as zero
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/lcd_palette_register_block.sv =====
// lcd_palette_register_block: LCD controller register file with color palette
// RAMs and pixel color lookup. Depends on lcdpal_pkg and lcdpal_cram.
//
//  channel  | dir | handshake              | contents
//  s_axis   | in  | tvalid/tready          | tuser mode, tdata request fields
//  m_axis   | out | tvalid/tready          | tuser flags, tdata read byte/pixel
//  cfg      | in  | cfg_valid_i/cfg_ready_o| color_mode
//
// Each request: accept + palette RAM read in ST_IDLE, then execute and
// write-back into the RAM and the output register. One request in flight.
// The next request is taken while a result waits if m_axis_tready is high.
// Reset clears FSM/LCD registers and, via valid bits, both palette RAMs at once.
// A stalled output holds the block in its accept state.
`default_nettype none

module lcd_palette_register_block (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,      // color_mode
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [1:0]  s_axis_tuser,    // [1:0] mode
  // [15:0] bus_address, [23:16] write_data, [25:24] new_status_mode,
  // [33:26] pixel_x, [35:34] color_num, [36] obj_sel, [39:37] palette_number
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [1:0]       m_axis_tuser,    // [0] pixel_valid, [1] palette_error
  // [7:0] read_data, [23:8] pixel_color, [38:24] pixel_address, [39] zero
  output logic [39:0]      m_axis_tdata
);

  localparam int unsigned AW = lcdpal_pkg::CRAM_AW;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic color_mode_q;
  logic [7:0] control_q, status_q, scy_q, scx_q, line_q, lcmp_q, wy_q, wx_q;
  logic [7:0] bgpal_q, obpal0_q, obpal1_q, bgptr_q, obptr_q;

  // captured request
  lcdpal_pkg::mode_e mode_q;
  logic [15:0] addr_q;
  logic [7:0]  wd_q;
  logic [1:0]  nsm_q;
  logic [7:0]  px_q;
  logic [1:0]  ci_q;
  logic        spr_q;
  logic [2:0]  pn_q;

  logic        out_valid_q;
  logic [39:0] out_data_q, out_data_d;
  logic [1:0]  out_user_q, out_user_d;

  logic s_acc;
  logic exec;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign exec          = (state_q == ST_EXEC);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // palette RAM read on accept
  lcdpal_pkg::cram_rd_t bg_rd, ob_rd;
  lcdpal_pkg::cram_wr_t bg_wr, ob_wr;
  logic [15:0] bg_rdata, ob_rdata;
  logic        in_render;
  logic [AW-1:0] render_idx;

  assign in_render  = (s_axis_tuser == lcdpal_pkg::MODE_RENDER);
  assign render_idx = AW'({s_axis_tdata[39:37], s_axis_tdata[35:34]});

  always_comb begin
    bg_rd.en   = s_acc;
    ob_rd.en   = s_acc;
    bg_rd.addr = in_render ? render_idx : bgptr_q[AW:1];
    ob_rd.addr = in_render ? render_idx : obptr_q[AW:1];
  end

  lcdpal_cram u_bg_cram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (bg_rd),
    .wr_i    (bg_wr),
    .rdata_o (bg_rdata)
  );

  lcdpal_cram u_ob_cram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (ob_rd),
    .wr_i    (ob_wr),
    .rdata_o (ob_rdata)
  );

  // execute stage
  logic [7:0]  rd_byte;
  logic [15:0] color;
  logic        pix_valid, pal_err;
  logic [15:0] paddr_full;
  logic [7:0]  mono_pal;
  logic [1:0]  shade;
  logic        wr_ctl, wr_stat, wr_scy, wr_scx, wr_line, wr_lcmp, wr_wy, wr_wx;
  logic        wr_bgpal, wr_obpal0, wr_obpal1, wr_bgptr, wr_obptr, wr_bgdat, wr_obdat;

  function automatic logic [15:0] merge_byte(logic [15:0] old, logic [7:0] ptr,
                                             logic [7:0] wd);
    logic [15:0] w;
    if (ptr[0]) begin
      w = {wd, old[7:0]} | lcdpal_pkg::COLOR_WRITTEN;
    end else begin
      w = {old[15:8], wd};
    end
    return w;
  endfunction

  function automatic logic [7:0] next_ptr(logic [7:0] ptr);
    logic [5:0] idx;
    idx = ptr[5:0] + 6'd1;
    return ptr[7] ? (lcdpal_pkg::PTR_AUTO_INC | {2'b00, idx}) : ptr;
  endfunction

  assign paddr_full = 16'(line_q) * 16'(lcdpal_pkg::SCREEN_WIDTH) + 16'(px_q);

  always_comb begin
    rd_byte   = '0;
    color     = '0;
    pix_valid = 1'b0;
    pal_err   = 1'b0;
    mono_pal  = bgpal_q;
    shade     = '0;
    wr_ctl = 1'b0; wr_stat = 1'b0; wr_scy = 1'b0; wr_scx = 1'b0;
    wr_line = 1'b0; wr_lcmp = 1'b0; wr_wy = 1'b0; wr_wx = 1'b0;
    wr_bgpal = 1'b0; wr_obpal0 = 1'b0; wr_obpal1 = 1'b0;
    wr_bgptr = 1'b0; wr_obptr = 1'b0; wr_bgdat = 1'b0; wr_obdat = 1'b0;

    unique case (mode_q)
      lcdpal_pkg::MODE_READ: begin
        unique case (addr_q)
          lcdpal_pkg::ADDR_CONTROL: rd_byte = control_q;
          lcdpal_pkg::ADDR_STATUS:  rd_byte = status_q;
          lcdpal_pkg::ADDR_SCY:     rd_byte = scy_q;
          lcdpal_pkg::ADDR_SCX:     rd_byte = scx_q;
          lcdpal_pkg::ADDR_LINE:    rd_byte = line_q;
          lcdpal_pkg::ADDR_LCMP:    rd_byte = lcmp_q;
          lcdpal_pkg::ADDR_WY:      rd_byte = wy_q;
          lcdpal_pkg::ADDR_WX:      rd_byte = wx_q;
          lcdpal_pkg::ADDR_BGPAL:   rd_byte = bgpal_q;
          lcdpal_pkg::ADDR_OBPAL0:  rd_byte = obpal0_q;
          lcdpal_pkg::ADDR_OBPAL1:  rd_byte = obpal1_q;
          lcdpal_pkg::ADDR_BGPTR:
            rd_byte = color_mode_q ? bgptr_q : lcdpal_pkg::BYTE_ALL_ONES;
          lcdpal_pkg::ADDR_OBPTR:
            rd_byte = color_mode_q ? obptr_q : lcdpal_pkg::BYTE_ALL_ONES;
          lcdpal_pkg::ADDR_BGDATA:
            rd_byte = !color_mode_q ? lcdpal_pkg::BYTE_ALL_ONES :
                      (bgptr_q[0] ? bg_rdata[15:8] : bg_rdata[7:0]);
          lcdpal_pkg::ADDR_OBDATA:
            rd_byte = !color_mode_q ? lcdpal_pkg::BYTE_ALL_ONES :
                      (obptr_q[0] ? ob_rdata[15:8] : ob_rdata[7:0]);
          default: rd_byte = lcdpal_pkg::BYTE_ALL_ONES;
        endcase
      end
      lcdpal_pkg::MODE_WRITE: begin
        unique case (addr_q)
          lcdpal_pkg::ADDR_CONTROL: wr_ctl    = 1'b1;
          lcdpal_pkg::ADDR_STATUS:  wr_stat   = 1'b1;
          lcdpal_pkg::ADDR_SCY:     wr_scy    = 1'b1;
          lcdpal_pkg::ADDR_SCX:     wr_scx    = 1'b1;
          lcdpal_pkg::ADDR_LINE:    wr_line   = 1'b1;
          lcdpal_pkg::ADDR_LCMP:    wr_lcmp   = 1'b1;
          lcdpal_pkg::ADDR_WY:      wr_wy     = 1'b1;
          lcdpal_pkg::ADDR_WX:      wr_wx     = 1'b1;
          lcdpal_pkg::ADDR_BGPAL:   wr_bgpal  = 1'b1;
          lcdpal_pkg::ADDR_OBPAL0:  wr_obpal0 = 1'b1;
          lcdpal_pkg::ADDR_OBPAL1:  wr_obpal1 = 1'b1;
          lcdpal_pkg::ADDR_BGPTR:   wr_bgptr  = color_mode_q;
          lcdpal_pkg::ADDR_OBPTR:   wr_obptr  = color_mode_q;
          lcdpal_pkg::ADDR_BGDATA:  wr_bgdat  = color_mode_q;
          lcdpal_pkg::ADDR_OBDATA:  wr_obdat  = color_mode_q;
          default: ;
        endcase
      end
      lcdpal_pkg::MODE_RENDER: begin
        if (color_mode_q) begin
          color     = spr_q ? ob_rdata : bg_rdata;
          pix_valid = 1'b1;
        end else begin
          // background has one mono palette, objects two
          if (spr_q) begin
            pal_err  = (pn_q > 3'd1);
            mono_pal = pn_q[0] ? obpal1_q : obpal0_q;
          end else begin
            pal_err  = (pn_q != 3'd0);
            mono_pal = bgpal_q;
          end
          pix_valid = !pal_err;
        end
        shade = 2'(mono_pal >> {ci_q, 1'b0});
        if (!color_mode_q && pix_valid) begin
          color = lcdpal_pkg::SHADES[shade];
        end
      end
      lcdpal_pkg::MODE_STATUS: ;
      default: ;
    endcase

    out_data_d = {1'b0, (pix_valid ? paddr_full[14:0] : 15'd0), color, rd_byte};
    out_user_d = {pal_err, pix_valid};
  end

  always_comb begin
    bg_wr.en   = exec && wr_bgdat;
    bg_wr.addr = bgptr_q[AW:1];
    bg_wr.data = merge_byte(bg_rdata, bgptr_q, wd_q);
    ob_wr.en   = exec && wr_obdat;
    ob_wr.addr = obptr_q[AW:1];
    ob_wr.data = merge_byte(ob_rdata, obptr_q, wd_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_acc) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      mode_q <= lcdpal_pkg::mode_e'(s_axis_tuser);
      addr_q <= s_axis_tdata[15:0];
      wd_q   <= s_axis_tdata[23:16];
      nsm_q  <= s_axis_tdata[25:24];
      px_q   <= s_axis_tdata[33:26];
      ci_q   <= s_axis_tdata[35:34];
      spr_q  <= s_axis_tdata[36];
      pn_q   <= s_axis_tdata[39:37];
    end
    if (exec) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      color_mode_q <= 1'b0;
      control_q    <= '0;
      status_q     <= '0;
      scy_q        <= '0;
      scx_q        <= '0;
      line_q       <= '0;
      lcmp_q       <= '0;
      wy_q         <= '0;
      wx_q         <= '0;
      bgpal_q      <= '0;
      obpal0_q     <= '0;
      obpal1_q     <= '0;
      bgptr_q      <= '0;
      obptr_q      <= '0;
    end else begin
      state_q <= state_d;
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        color_mode_q <= cfg_data_i;
      end
      if (exec) begin
        if (wr_ctl)    control_q <= wd_q;
        if (wr_scy)    scy_q     <= wd_q;
        if (wr_scx)    scx_q     <= wd_q;
        if (wr_line)   line_q    <= wd_q;
        if (wr_lcmp)   lcmp_q    <= wd_q;
        if (wr_wy)     wy_q      <= wd_q;
        if (wr_wx)     wx_q      <= wd_q;
        if (wr_bgpal)  bgpal_q   <= wd_q;
        if (wr_obpal0) obpal0_q  <= wd_q;
        if (wr_obpal1) obpal1_q  <= wd_q;
        if (wr_bgptr)  bgptr_q   <= wd_q;
        if (wr_obptr)  obptr_q   <= wd_q;
        if (wr_bgdat)  bgptr_q   <= next_ptr(bgptr_q);
        if (wr_obdat)  obptr_q   <= next_ptr(obptr_q);
        // low status bits belong to the pixel engine
        if (wr_stat) begin
          status_q <= (status_q & ~lcdpal_pkg::STATUS_WR_MASK) |
                      (wd_q & lcdpal_pkg::STATUS_WR_MASK);
        end
        if (mode_q == lcdpal_pkg::MODE_STATUS) begin
          status_q <= {status_q[7:2], nsm_q};
        end
      end
    end
  end

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (state_q == ST_EXEC))
    else $error("accepted request did not enter execute");

  a_exec_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> out_valid_q)
    else $error("executed request produced no result");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_user_q[0] && out_user_q[1]))
    else $error("pixel_valid and palette_error both set");

  a_no_accept_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |-> !s_axis_tready)
    else $error("request accepted while another executes");

endmodule

`default_nettype wire

// ===== verif/tb_lcd_palette_register_block.sv =====
// tb_lcd_palette_register_block: self-checking testbench for the LCD palette
// register block. Keeps its own copy of the registers and palette RAMs and
// checks every reply. Depends on lcdpal_pkg and lcd_palette_register_block.

module tb_lcd_palette_register_block;

  localparam int unsigned MAX_WAIT    = 14;
  localparam int unsigned HANG_LIMIT  = 300;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam logic [15:0] ADDR_UNUSED = 16'hFF46;  // hole in the register map

  typedef struct packed {
    logic [7:0]  rd;
    logic [15:0] color;
    logic [14:0] addr;
    logic        valid;
    logic        err;
  } lcd_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser;   // [1:0] mode
  // [15:0] bus_address, [23:16] write_data, [25:24] new_status_mode,
  // [33:26] pixel_x, [35:34] color_num, [36] obj_sel, [39:37] palette_number
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [1:0]  m_axis_tuser;   // [0] pixel_valid, [1] palette_error
  // [7:0] read_data, [23:8] pixel_color, [38:24] pixel_address, [39] zero
  logic [39:0] m_axis_tdata;

  // register file image
  logic        color_mode_m;
  logic [7:0]  ctrl_m, stat_m, scy_m, scx_m, ly_m, lyc_m, wy_m, wx_m;
  logic [7:0]  bgp_m, obp0_m, obp1_m, bg_ptr_m, obj_ptr_m;
  logic [15:0] bg_cram_m [lcdpal_pkg::COLOR_RAM_WORDS];
  logic [15:0] obj_cram_m [lcdpal_pkg::COLOR_RAM_WORDS];

  lcd_reply_t  replies_due [$];
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned idle_cycles;
  bit          steady_flow;

  lcd_palette_register_block uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // four fixed gray shades of the monochrome machine
  function automatic logic [15:0] shade_color(input logic [1:0] s);
    case (s)
      2'd0:    return 16'hEBFC;
      2'd1:    return 16'hBB11;
      2'd2:    return 16'hA9A6;
      default: return 16'h9061;
    endcase
  endfunction

  function automatic logic [7:0] cram_byte(input logic obj, input logic [7:0] ptr);
    logic [15:0] w;
    w = obj ? obj_cram_m[ptr[5:1]] : bg_cram_m[ptr[5:1]];
    return ptr[0] ? w[15:8] : w[7:0];
  endfunction

  task automatic cram_store(input logic obj, input logic [7:0] wd);
    logic [7:0]  ptr;
    logic [15:0] w;
    ptr = obj ? obj_ptr_m : bg_ptr_m;
    w   = obj ? obj_cram_m[ptr[5:1]] : bg_cram_m[ptr[5:1]];
    // high byte write also marks the word as written
    if (ptr[0]) w = {1'b1, wd[6:0], w[7:0]};
    else w[7:0] = wd;
    if (obj) obj_cram_m[ptr[5:1]] = w;
    else bg_cram_m[ptr[5:1]] = w;
    if (ptr[7]) ptr = {2'b10, ptr[5:0] + 6'd1};
    if (obj) obj_ptr_m = ptr;
    else bg_ptr_m = ptr;
  endtask

  task automatic emulate_lcd_regs(input lcdpal_pkg::mode_e md, input logic [15:0] addr,
                                  input logic [7:0] wd, input logic [1:0] nsm,
                                  input logic [7:0] px, input logic [1:0] ci,
                                  input logic spr, input logic [2:0] pn);
    lcd_reply_t  r;
    logic [4:0]  wi;
    logic [7:0]  pal;
    logic [7:0]  sh;
    int unsigned pa;
    r = '0;
    case (md)
      lcdpal_pkg::MODE_READ: begin
        case (addr)
          lcdpal_pkg::ADDR_CONTROL: r.rd = ctrl_m;
          lcdpal_pkg::ADDR_STATUS:  r.rd = stat_m;
          lcdpal_pkg::ADDR_SCY:     r.rd = scy_m;
          lcdpal_pkg::ADDR_SCX:     r.rd = scx_m;
          lcdpal_pkg::ADDR_LINE:    r.rd = ly_m;
          lcdpal_pkg::ADDR_LCMP:    r.rd = lyc_m;
          lcdpal_pkg::ADDR_WY:      r.rd = wy_m;
          lcdpal_pkg::ADDR_WX:      r.rd = wx_m;
          lcdpal_pkg::ADDR_BGPAL:   r.rd = bgp_m;
          lcdpal_pkg::ADDR_OBPAL0:  r.rd = obp0_m;
          lcdpal_pkg::ADDR_OBPAL1:  r.rd = obp1_m;
          lcdpal_pkg::ADDR_BGPTR:   r.rd = color_mode_m ? bg_ptr_m : 8'hFF;
          lcdpal_pkg::ADDR_OBPTR:   r.rd = color_mode_m ? obj_ptr_m : 8'hFF;
          lcdpal_pkg::ADDR_BGDATA:
            r.rd = color_mode_m ? cram_byte(1'b0, bg_ptr_m) : 8'hFF;
          lcdpal_pkg::ADDR_OBDATA:
            r.rd = color_mode_m ? cram_byte(1'b1, obj_ptr_m) : 8'hFF;
          default:      r.rd = 8'hFF;
        endcase
      end
      lcdpal_pkg::MODE_WRITE: begin
        case (addr)
          lcdpal_pkg::ADDR_CONTROL: ctrl_m = wd;
          lcdpal_pkg::ADDR_STATUS:  stat_m = {wd[7:2], stat_m[1:0]};
          lcdpal_pkg::ADDR_SCY:     scy_m = wd;
          lcdpal_pkg::ADDR_SCX:     scx_m = wd;
          lcdpal_pkg::ADDR_LINE:    ly_m = wd;
          lcdpal_pkg::ADDR_LCMP:    lyc_m = wd;
          lcdpal_pkg::ADDR_WY:      wy_m = wd;
          lcdpal_pkg::ADDR_WX:      wx_m = wd;
          lcdpal_pkg::ADDR_BGPAL:   bgp_m = wd;
          lcdpal_pkg::ADDR_OBPAL0:  obp0_m = wd;
          lcdpal_pkg::ADDR_OBPAL1:  obp1_m = wd;
          lcdpal_pkg::ADDR_BGPTR:   if (color_mode_m) bg_ptr_m = wd;
          lcdpal_pkg::ADDR_OBPTR:   if (color_mode_m) obj_ptr_m = wd;
          lcdpal_pkg::ADDR_BGDATA:  if (color_mode_m) cram_store(1'b0, wd);
          lcdpal_pkg::ADDR_OBDATA:  if (color_mode_m) cram_store(1'b1, wd);
          default: ;
        endcase
      end
      lcdpal_pkg::MODE_RENDER: begin
        wi = {pn, ci};
        if (color_mode_m) begin
          r.color = spr ? obj_cram_m[wi] : bg_cram_m[wi];
          r.valid = 1'b1;
        end else if (spr ? (pn <= 3'd1) : (pn == 3'd0)) begin
          pal     = spr ? (pn[0] ? obp1_m : obp0_m) : bgp_m;
          sh      = pal >> (2 * ci);
          r.color = shade_color(sh[1:0]);
          r.valid = 1'b1;
        end else begin
          r.err = 1'b1;
        end
        if (r.valid) begin
          pa     = ly_m * lcdpal_pkg::SCREEN_WIDTH + px;
          r.addr = pa[14:0];
        end
      end
      default: stat_m[1:0] = nsm;
    endcase
    replies_due.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // one request on s_axis; called at a falling edge, returns at one
  task automatic send_request(input lcdpal_pkg::mode_e md, input logic [15:0] addr,
                              input logic [7:0] wd, input logic [1:0] nsm,
                              input logic [7:0] px, input logic [1:0] ci,
                              input logic spr, input logic [2:0] pn);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
    repeat (gap) @(negedge clk_i);
    s_axis_tuser  = md;
    s_axis_tdata  = {pn, spr, ci, px, nsm, wd, addr};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    emulate_lcd_regs(md, addr, wd, nsm, px, ci, spr, pn);
    requests_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // unused fields carry random junk so the block must ignore them
  task automatic bus_read(input logic [15:0] addr);
    send_request(lcdpal_pkg::MODE_READ, addr, 8'($urandom), 2'($urandom), 8'($urandom),
                 2'($urandom), 1'($urandom), 3'($urandom));
  endtask

  task automatic bus_write(input logic [15:0] addr, input logic [7:0] wd);
    send_request(lcdpal_pkg::MODE_WRITE, addr, wd, 2'($urandom), 8'($urandom),
                 2'($urandom), 1'($urandom), 3'($urandom));
  endtask

  task automatic render(input logic [7:0] px, input logic [1:0] ci, input logic spr,
                        input logic [2:0] pn);
    send_request(lcdpal_pkg::MODE_RENDER, 16'($urandom), 8'($urandom), 2'($urandom),
                 px, ci, spr, pn);
  endtask

  task automatic set_status(input logic [1:0] nsm);
    send_request(lcdpal_pkg::MODE_STATUS, 16'($urandom), 8'($urandom), nsm,
                 8'($urandom), 2'($urandom), 1'($urandom), 3'($urandom));
  endtask

  task automatic wait_replies_drained();
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_color_mode(input logic value);
    wait_replies_drained();
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    color_mode_m = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [15:0] reg_address();
    case ($urandom_range(0, 19))
      0:       return lcdpal_pkg::ADDR_CONTROL;
      1:       return lcdpal_pkg::ADDR_STATUS;
      2:       return lcdpal_pkg::ADDR_SCY;
      3:       return lcdpal_pkg::ADDR_SCX;
      4:       return lcdpal_pkg::ADDR_LINE;
      5:       return lcdpal_pkg::ADDR_LCMP;
      6:       return lcdpal_pkg::ADDR_BGPAL;
      7:       return lcdpal_pkg::ADDR_OBPAL0;
      8:       return lcdpal_pkg::ADDR_OBPAL1;
      9:       return lcdpal_pkg::ADDR_WY;
      10:      return lcdpal_pkg::ADDR_WX;
      11:      return ADDR_UNUSED;
      12, 13:  return lcdpal_pkg::ADDR_BGPTR;
      14, 15:  return lcdpal_pkg::ADDR_OBPTR;
      16, 17:  return lcdpal_pkg::ADDR_BGDATA;
      default: return lcdpal_pkg::ADDR_OBDATA;
    endcase
  endfunction

  task automatic test_reset_values();
    bus_read(lcdpal_pkg::ADDR_CONTROL);
    bus_read(lcdpal_pkg::ADDR_BGDATA);
    bus_read(16'h0000);
  endtask

  task automatic test_mono_registers();
    bus_write(lcdpal_pkg::ADDR_STATUS, 8'hFF);  // low two bits must stay
    set_status(2'd3);
    bus_read(lcdpal_pkg::ADDR_STATUS);
    bus_write(lcdpal_pkg::ADDR_LINE, 8'hFF);    // forces frame address wrap
  endtask

  task automatic test_mono_render();
    bus_write(lcdpal_pkg::ADDR_BGPAL, 8'hE4);
    bus_write(lcdpal_pkg::ADDR_OBPAL1, 8'h1B);
    render(8'd159, 2'd3, 1'b0, 3'd0);
    render(8'd0, 2'd0, 1'b0, 3'd7);
    render(8'd255, 2'd0, 1'b1, 3'd1);
    render(8'd0, 2'd1, 1'b1, 3'd2);
    bus_write(lcdpal_pkg::ADDR_BGPTR, 8'h85);   // ignored without color mode
    bus_read(lcdpal_pkg::ADDR_BGPTR);
  endtask

  task automatic test_color_palette();
    set_color_mode(1'b1);
    bus_write(lcdpal_pkg::ADDR_BGPTR, 8'hBF);   // last byte, auto-increment wraps to 0
    bus_write(lcdpal_pkg::ADDR_BGDATA, 8'hFF);
    bus_write(lcdpal_pkg::ADDR_BGDATA, 8'h00);
    bus_read(lcdpal_pkg::ADDR_BGPTR);
    bus_write(lcdpal_pkg::ADDR_OBPTR, 8'h01);
    bus_write(lcdpal_pkg::ADDR_OBDATA, 8'h7F);
    bus_read(lcdpal_pkg::ADDR_OBDATA);
    render(8'd0, 2'd3, 1'b0, 3'd7);
    render(8'd159, 2'd0, 1'b1, 3'd0);
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    int unsigned pick;
    bit          paused;
    logic        obj;
    logic [7:0]  ptr;
    logic [2:0]  pn;
    paused = 1'b0;
    for (int phase = 0; phase < 6; phase++) begin
      set_color_mode((phase % 2) == 0);
      steady_flow = (phase == 3);
      target = requests_sent + PHASE_ITEMS;
      while (requests_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          set_status(2'($urandom));
        end else if (pick < 35) begin
          pn = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 1)) : 3'($urandom);
          render(8'((pick < 32) ? $urandom_range(0, lcdpal_pkg::SCREEN_WIDTH - 1) :
                                  $urandom_range(0, 255)),
                 2'($urandom), 1'($urandom), pn);
        end else if (pick < 55) begin
          bus_read(reg_address());
        end else if (pick < 82) begin
          bus_write(reg_address(), 8'($urandom));
        end else if (pick < 88) begin
          if ($urandom_range(0, 1)) bus_read(16'($urandom));
          else bus_write(16'($urandom), 8'($urandom));
        end else begin
          // palette load: pointer then a run of data bytes
          obj    = 1'($urandom_range(0, 1));
          ptr    = 8'($urandom);
          ptr[7] = ($urandom_range(0, 3) != 0);
          bus_write(obj ? lcdpal_pkg::ADDR_OBPTR : lcdpal_pkg::ADDR_BGPTR, ptr);
          repeat ($urandom_range(2, 8))
            bus_write(obj ? lcdpal_pkg::ADDR_OBDATA : lcdpal_pkg::ADDR_BGDATA,
                      8'($urandom));
        end
        if (phase == 4 && !paused && requests_sent >= target - PHASE_ITEMS / 2) begin
          wait_replies_drained();
          paused = 1'b1;
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  // receiver: random stall before each reply, none while steady_flow is set
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
      m_axis_tready = 1'b0;
      repeat (stall) @(negedge clk_i);
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : reply_check
    lcd_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (replies_due.size() == 0) begin
        report_mismatch("reply with none due", m_axis_tdata[31:0], 32'd0);
      end else begin
        want = replies_due.pop_front();
        if (m_axis_tdata[7:0] !== want.rd)
          report_mismatch("read_data", 32'(m_axis_tdata[7:0]), 32'(want.rd));
        if (m_axis_tdata[23:8] !== want.color)
          report_mismatch("pixel_color", 32'(m_axis_tdata[23:8]), 32'(want.color));
        if (m_axis_tdata[38:24] !== want.addr)
          report_mismatch("pixel_address", 32'(m_axis_tdata[38:24]), 32'(want.addr));
        if (m_axis_tdata[39] !== 1'b0)
          report_mismatch("tdata pad bit", 32'(m_axis_tdata[39]), 32'd0);
        if (m_axis_tuser[0] !== want.valid)
          report_mismatch("pixel_valid", 32'(m_axis_tuser[0]), 32'(want.valid));
        if (m_axis_tuser[1] !== want.err)
          report_mismatch("palette_error", 32'(m_axis_tuser[1]), 32'(want.err));
      end
    end
  end

  // hang detector: cycles without any request moving on any channel
  initial begin
    idle_cycles = 0;
    wait (rst_ni === 1'b1);
    while (idle_cycles < HANG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_lcd_palette_register_block failed");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = lcdpal_pkg::MODE_READ;
    s_axis_tdata  = '0;
    steady_flow   = 1'b0;
    mismatches    = 0;
    requests_sent = 0;
    color_mode_m  = 1'b0;
    {ctrl_m, stat_m, scy_m, scx_m, ly_m, lyc_m, wy_m, wx_m} = '0;
    {bgp_m, obp0_m, obp1_m, bg_ptr_m, obj_ptr_m} = '0;
    for (int i = 0; i < lcdpal_pkg::COLOR_RAM_WORDS; i++) begin
      bg_cram_m[i]  = '0;
      obj_cram_m[i] = '0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_mono_registers();
    test_mono_render();
    test_color_palette();
    test_random_traffic();

    wait_replies_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("tb_lcd_palette_register_block passed");
    end else begin
      $display("tb_lcd_palette_register_block failed");
    end
    $finish;
  end

endmodule
